### hw/rtl/rvaa_pkg.sv
// Shared types and constants for the reference vector angle association block.
// Holds operation and register codes, the command and result beats, and the
// back end state encoding. Depends on nothing.
`timescale 1ns / 1ps

package rvaa_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_BATCH = 2'd2;

  localparam logic REG_OBJECTIVE_COUNT = 1'b0;
  localparam logic REG_VECTOR_COUNT    = 1'b1;

  localparam logic [4:0] OBJECTIVE_COUNT_RESET = 5'd3;
  localparam logic [8:0] VECTOR_COUNT_RESET    = 9'd1;

  localparam logic [8:0] CNT_MAX = 9'd511;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_POINT,
    CMD_ASSOC,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        wr;
    logic [7:0]  vec;
    logic [3:0]  obj;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [8:0] point_number;
    logic [7:0] chosen_vector;
    logic [8:0] slot;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DOT,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_CMP_START,
    ST_CMP_WAIT,
    ST_NEXT,
    ST_CNT_RD,
    ST_CNT_WR
  } back_state_t;

endpackage

### hw/rtl/reference_vector_angle_association_top.sv
// Top level of the reference vector angle association block.
// Holds the configuration registers and connects front end, command queue, back end and
// result queue. Depends on rvaa_pkg, rvaa_front, rvaa_fifo and rvaa_back.
//
// The block associates each point with the stored reference vector of smallest angle, using
// exact integer cross-multiplication, and hands out the point number, the chosen vector and
// its slot. Input beats enter a four-entry command queue, so the input side keeps accepting
// while the back end works, and results wait in a two-entry result queue. A load, a non-final
// point element or a batch start is taken by the back end without leaving its idle state. A
// point's final element starts a scan over the nvec vectors in use; for each vector, dot
// product and norm over the nobj objectives in use are formed through the reference table
// read port, then a 3x3 limb squaring and two 5x3 limb cross products run in the wide
// multipliers, each of which forms one 32x32 partial product per cycle. The first nonzero
// vector and all-zero vectors skip the cross products. No clearing pass follows reset.
`timescale 1ns / 1ps

module reference_vector_angle_association_top #(
  parameter int MAX_VECTORS    = 256,
  parameter int MAX_OBJECTIVES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation,
  input  logic [7:0]         vector_index,
  input  logic [3:0]         objective_index,
  input  logic signed [31:0] value,
  input  logic               point_last,
  output logic               empty,
  input  logic               pop,
  output logic [8:0]         point_number,
  output logic [7:0]         chosen_vector,
  output logic [8:0]         slot,
  input  logic               write_enable,
  input  logic               register_index,
  input  logic [8:0]         write_data
);

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  logic [4:0]     objective_count;
  logic [8:0]     vector_count;
  rvaa_pkg::cmd_t cmd_in;
  rvaa_pkg::cmd_t cmd_out;
  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_empty;
  logic           cmd_pop;
  rvaa_pkg::res_t res_in;
  rvaa_pkg::res_t res_out;
  logic           res_push;
  logic           res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      objective_count <= rvaa_pkg::OBJECTIVE_COUNT_RESET;
      vector_count    <= rvaa_pkg::VECTOR_COUNT_RESET;
    end else if (write_enable) begin
      case (register_index)
        rvaa_pkg::REG_OBJECTIVE_COUNT: begin
          objective_count <= write_data[4:0];
        end
        rvaa_pkg::REG_VECTOR_COUNT: begin
          vector_count <= write_data;
        end
        default: begin
          vector_count <= vector_count;
        end
      endcase
    end
  end

  rvaa_front #(
    .MAX_VECTORS   (MAX_VECTORS),
    .MAX_OBJECTIVES(MAX_OBJECTIVES)
  ) u_front (
    .push           (push),
    .full           (full),
    .operation      (operation),
    .vector_index   (vector_index),
    .objective_index(objective_index),
    .value          (value),
    .point_last     (point_last),
    .cmd_full       (cmd_full),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  rvaa_fifo #(
    .WIDTH($bits(rvaa_pkg::cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_out),
    .empty(cmd_empty)
  );

  rvaa_back #(
    .MAX_VECTORS   (MAX_VECTORS),
    .MAX_OBJECTIVES(MAX_OBJECTIVES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_empty      (cmd_empty),
    .cmd            (cmd_out),
    .cmd_pop        (cmd_pop),
    .res_full       (res_full),
    .res_push       (res_push),
    .res            (res_in),
    .objective_count(objective_count),
    .vector_count   (vector_count)
  );

  rvaa_fifo #(
    .WIDTH($bits(rvaa_pkg::res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_out),
    .empty(empty)
  );

  assign point_number  = res_out.point_number;
  assign chosen_vector = res_out.chosen_vector;
  assign slot          = res_out.slot;

endmodule

### hw/rtl/rvaa_fifo.sv
// Small register queue used between the front end and the back end and on the result side.
// Depth must be a power of two. Depends on nothing.
`timescale 1ns / 1ps

module rvaa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W:0]   count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == (PTR_W + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wp <= wp + PTR_W'(1);
      end
      if (pop_ok) begin
        rp <= rp + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wp] <= wdata;
    end
  end

endmodule

### hw/rtl/rvaa_front.sv
// Front end: accepts input beats, drops those that have no effect and classifies the rest.
// Depends on rvaa_pkg for the operation codes and the command beat.
`timescale 1ns / 1ps

module rvaa_front #(
  parameter int MAX_VECTORS    = 256,
  parameter int MAX_OBJECTIVES = 16
) (
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation,
  input  logic [7:0]          vector_index,
  input  logic [3:0]          objective_index,
  input  logic signed [31:0]  value,
  input  logic                point_last,
  input  logic                cmd_full,
  output logic                cmd_push,
  output rvaa_pkg::cmd_t      cmd
);

  logic obj_ok;
  logic vec_ok;
  logic keep;

  assign obj_ok = (32'(objective_index) < 32'(MAX_OBJECTIVES));
  assign vec_ok = (32'(vector_index) < 32'(MAX_VECTORS));
  assign full   = cmd_full;

  always_comb begin
    keep      = 1'b0;
    cmd.kind  = rvaa_pkg::CMD_CLEAR;
    cmd.wr    = obj_ok;
    cmd.vec   = vector_index;
    cmd.obj   = objective_index;
    cmd.value = value;
    case (operation)
      rvaa_pkg::OP_LOAD: begin
        cmd.kind = rvaa_pkg::CMD_LOAD;
        keep     = vec_ok && obj_ok;
      end
      rvaa_pkg::OP_POINT: begin
        cmd.kind = point_last ? rvaa_pkg::CMD_ASSOC : rvaa_pkg::CMD_POINT;
        keep     = point_last || obj_ok;
      end
      rvaa_pkg::OP_BATCH: begin
        cmd.kind = rvaa_pkg::CMD_CLEAR;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push = push && !cmd_full && keep;

endmodule

### hw/rtl/rvaa_wmul.sv
// Multi-cycle wide unsigned multiplier built from one registered 32x32 partial product.
// It takes one limb pair per cycle and raises done for one cycle when p is final.
// Depends on nothing.
`timescale 1ns / 1ps

module rvaa_wmul #(
  parameter int AW = 68,
  parameter int BW = 68
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] p
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int PW = 32 * (NA + NB);
  localparam int IW = (NA > 1) ? $clog2(NA) : 1;
  localparam int JW = (NB > 1) ? $clog2(NB) : 1;
  localparam int SW = $clog2(NA + NB);

  logic [32*NA-1:0] a_pad;
  logic [32*NB-1:0] b_pad;
  logic [IW-1:0]    i;
  logic [JW-1:0]    j;
  logic             issuing;
  logic             last_pair;
  logic             prod_vld;
  logic             prod_last;
  logic [63:0]      prod;
  logic [SW-1:0]    prod_sh;
  logic [PW-1:0]    acc;

  assign a_pad     = (32 * NA)'(a);
  assign b_pad     = (32 * NB)'(b);
  assign last_pair = (i == IW'(NA - 1)) && (j == JW'(NB - 1));
  assign p         = acc[AW+BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      prod_vld  <= 1'b0;
      prod_last <= 1'b0;
      done      <= 1'b0;
      i         <= '0;
      j         <= '0;
    end else begin
      prod_vld  <= issuing;
      prod_last <= issuing && last_pair;
      done      <= prod_vld && prod_last;
      if (start) begin
        issuing <= 1'b1;
        i       <= '0;
        j       <= '0;
      end else if (issuing) begin
        if (last_pair) begin
          issuing <= 1'b0;
        end
        if (j == JW'(NB - 1)) begin
          j <= '0;
          i <= i + IW'(1);
        end else begin
          j <= j + JW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod    <= {32'd0, a_pad[32*i +: 32]} * {32'd0, b_pad[32*j +: 32]};
    prod_sh <= SW'(i) + SW'(j);
    if (start) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + (PW'(prod) << {prod_sh, 5'd0});
    end
  end

endmodule

### hw/rtl/rvaa_back.sv
// Back end: executes queued commands, holds the reference table, the point buffer and the
// association counters, and runs the exact smallest-angle search. Depends on rvaa_pkg and
// rvaa_wmul.
`timescale 1ns / 1ps

module rvaa_back #(
  parameter int MAX_VECTORS    = 256,
  parameter int MAX_OBJECTIVES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_empty,
  input  rvaa_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output rvaa_pkg::res_t res,
  input  logic [4:0]     objective_count,
  input  logic [8:0]     vector_count
);

  localparam int OBJ_W     = $clog2(MAX_OBJECTIVES);
  localparam int VEC_W     = $clog2(MAX_VECTORS);
  localparam int NO_W      = OBJ_W + 1;
  localparam int NV_W      = VEC_W + 1;
  localparam int K_W       = NO_W + 1;
  localparam int MAG_W     = 64 + OBJ_W;
  localparam int DOT_W     = MAG_W + 1;
  localparam int NRM_W     = MAG_W;
  localparam int DSQ_W     = 2 * MAG_W;
  localparam int CMP_W     = DSQ_W + NRM_W;
  localparam int TAB_DEPTH = MAX_VECTORS << OBJ_W;
  localparam int TAB_AW    = VEC_W + OBJ_W;

  rvaa_pkg::back_state_t state;
  rvaa_pkg::back_state_t state_next;

  logic [NO_W-1:0]   nobj;
  logic [NV_W-1:0]   nvec;
  logic [31:0]       pbuf [MAX_OBJECTIVES];
  logic              point_any;

  logic [31:0]       ref_mem [TAB_DEPTH];
  logic              tab_we;
  logic [TAB_AW-1:0] tab_wa;
  logic              tab_re;
  logic [TAB_AW-1:0] tab_ra;
  logic [31:0]       tab_q;

  logic [K_W-1:0]    k;
  logic [VEC_W-1:0]  v;
  logic              dot_last;
  logic              vec_last;
  logic              rd_vld;
  logic [OBJ_W-1:0]  rd_k;
  logic [31:0]       p_sel;
  logic [31:0]       w_mag;
  logic [31:0]       p_mag;
  logic              mul_vld;
  logic              mul_neg;
  logic [63:0]       mul_wp;
  logic [63:0]       mul_ww;
  logic [DOT_W-1:0]  dot_acc;
  logic [NRM_W-1:0]  norm_acc;
  logic [MAG_W-1:0]  d_mag;
  logic [NRM_W-1:0]  cn;

  logic              found;
  logic [VEC_W-1:0]  best_v;
  logic [DSQ_W-1:0]  bd2;
  logic [NRM_W-1:0]  bn;
  logic              take_first;
  logic              take_better;

  logic              sq_start;
  logic              sq_done;
  logic [DSQ_W-1:0]  sq_p;
  logic              cmp_start;
  logic              lhs_done;
  logic              rhs_done;
  logic [CMP_W-1:0]  lhs_p;
  logic [CMP_W-1:0]  rhs_p;

  logic [VEC_W-1:0]  chosen;
  logic [8:0]        cnt_mem [MAX_VECTORS];
  logic [MAX_VECTORS-1:0] cnt_vld;
  logic              cnt_re;
  logic [8:0]        cnt_q;
  logic              cnt_hit;
  logic [8:0]        slot;
  logic [8:0]        slot_next;
  logic [8:0]        point_counter;

  always_comb begin
    if (32'(objective_count) > 32'(MAX_OBJECTIVES)) begin
      nobj = NO_W'(MAX_OBJECTIVES);
    end else begin
      nobj = NO_W'(objective_count);
    end
    if (vector_count == '0) begin
      nvec = NV_W'(1);
    end else if (32'(vector_count) > 32'(MAX_VECTORS)) begin
      nvec = NV_W'(MAX_VECTORS);
    end else begin
      nvec = NV_W'(vector_count);
    end
  end

  always_comb begin
    point_any = 1'b0;
    for (int i = 0; i < MAX_OBJECTIVES; i++) begin
      if ((NO_W'(i) < nobj) && (pbuf[i] != '0)) begin
        point_any = 1'b1;
      end
    end
  end

  assign dot_last    = (k == K_W'(nobj) + K_W'(2));
  assign vec_last    = (NV_W'(v) + NV_W'(1) == nvec);
  assign take_first  = (state == rvaa_pkg::ST_SQ_WAIT) && sq_done && (cn != '0) && !found;
  assign take_better = (state == rvaa_pkg::ST_CMP_WAIT) && lhs_done && rhs_done &&
                       (lhs_p > rhs_p);
  assign chosen      = found ? best_v : '0;
  assign slot        = cnt_hit ? cnt_q : '0;
  assign slot_next   = (slot == rvaa_pkg::CNT_MAX) ? slot : slot + 9'd1;

  always_comb begin
    state_next = state;
    case (state)
      rvaa_pkg::ST_IDLE: begin
        if (!cmd_empty && (cmd.kind == rvaa_pkg::CMD_ASSOC)) begin
          state_next = rvaa_pkg::ST_CHECK;
        end
      end
      rvaa_pkg::ST_CHECK: begin
        state_next = point_any ? rvaa_pkg::ST_DOT : rvaa_pkg::ST_CNT_RD;
      end
      rvaa_pkg::ST_DOT: begin
        if (dot_last) begin
          state_next = rvaa_pkg::ST_SQ_START;
        end
      end
      rvaa_pkg::ST_SQ_START: begin
        state_next = rvaa_pkg::ST_SQ_WAIT;
      end
      rvaa_pkg::ST_SQ_WAIT: begin
        if (sq_done) begin
          if ((cn == '0) || !found) begin
            state_next = rvaa_pkg::ST_NEXT;
          end else begin
            state_next = rvaa_pkg::ST_CMP_START;
          end
        end
      end
      rvaa_pkg::ST_CMP_START: begin
        state_next = rvaa_pkg::ST_CMP_WAIT;
      end
      rvaa_pkg::ST_CMP_WAIT: begin
        if (lhs_done && rhs_done) begin
          state_next = rvaa_pkg::ST_NEXT;
        end
      end
      rvaa_pkg::ST_NEXT: begin
        state_next = vec_last ? rvaa_pkg::ST_CNT_RD : rvaa_pkg::ST_DOT;
      end
      rvaa_pkg::ST_CNT_RD: begin
        state_next = rvaa_pkg::ST_CNT_WR;
      end
      rvaa_pkg::ST_CNT_WR: begin
        if (!res_full) begin
          state_next = rvaa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rvaa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop           = (state == rvaa_pkg::ST_IDLE) && !cmd_empty;
    tab_we            = cmd_pop && (cmd.kind == rvaa_pkg::CMD_LOAD);
    tab_wa            = {VEC_W'(cmd.vec), OBJ_W'(cmd.obj)};
    tab_re            = (state == rvaa_pkg::ST_DOT) && (k < K_W'(nobj));
    tab_ra            = {v, OBJ_W'(k)};
    sq_start          = (state == rvaa_pkg::ST_SQ_START);
    cmp_start         = (state == rvaa_pkg::ST_CMP_START);
    cnt_re            = (state == rvaa_pkg::ST_CNT_RD);
    res_push          = (state == rvaa_pkg::ST_CNT_WR) && !res_full;
    res.point_number  = point_counter;
    res.chosen_vector = 8'(chosen);
    res.slot          = slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rvaa_pkg::ST_IDLE;
      k             <= '0;
      v             <= '0;
      found         <= 1'b0;
      rd_vld        <= 1'b0;
      mul_vld       <= 1'b0;
      cnt_vld       <= '0;
      point_counter <= '0;
    end else begin
      state   <= state_next;
      rd_vld  <= tab_re;
      mul_vld <= rd_vld;
      if (cmd_pop && (cmd.kind == rvaa_pkg::CMD_CLEAR)) begin
        cnt_vld       <= '0;
        point_counter <= '0;
      end
      if (res_push) begin
        cnt_vld[chosen] <= 1'b1;
        if (point_counter != rvaa_pkg::CNT_MAX) begin
          point_counter <= point_counter + 9'd1;
        end
      end
      if (state == rvaa_pkg::ST_CHECK) begin
        k     <= '0;
        v     <= '0;
        found <= 1'b0;
      end else if (state == rvaa_pkg::ST_DOT) begin
        k <= k + K_W'(1);
      end else if (state == rvaa_pkg::ST_NEXT) begin
        k <= '0;
        v <= v + VEC_W'(1);
      end
      if (take_first) begin
        found <= 1'b1;
      end
    end
  end

  always_comb begin
    p_sel = pbuf[rd_k];
    w_mag = tab_q[31] ? (~tab_q + 32'd1) : tab_q;
    p_mag = p_sel[31] ? (~p_sel + 32'd1) : p_sel;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.wr &&
        ((cmd.kind == rvaa_pkg::CMD_POINT) || (cmd.kind == rvaa_pkg::CMD_ASSOC))) begin
      pbuf[OBJ_W'(cmd.obj)] <= cmd.value;
    end
    rd_k    <= OBJ_W'(k);
    mul_wp  <= {32'd0, w_mag} * {32'd0, p_mag};
    mul_ww  <= {32'd0, w_mag} * {32'd0, w_mag};
    mul_neg <= tab_q[31] ^ p_sel[31];
    if ((state == rvaa_pkg::ST_CHECK) || (state == rvaa_pkg::ST_NEXT)) begin
      dot_acc  <= '0;
      norm_acc <= '0;
    end else if (mul_vld) begin
      dot_acc  <= mul_neg ? dot_acc - DOT_W'(mul_wp) : dot_acc + DOT_W'(mul_wp);
      norm_acc <= norm_acc + NRM_W'(mul_ww);
    end
    if ((state == rvaa_pkg::ST_DOT) && dot_last) begin
      d_mag <= dot_acc[DOT_W-1] ? MAG_W'(-dot_acc) : MAG_W'(dot_acc);
      cn    <= norm_acc;
    end
    if (take_first || take_better) begin
      best_v <= v;
      bd2    <= sq_p;
      bn     <= cn;
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      ref_mem[tab_wa] <= cmd.value;
    end
    if (tab_re) begin
      tab_q <= ref_mem[tab_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      cnt_mem[chosen] <= slot_next;
    end
    if (cnt_re) begin
      cnt_q   <= cnt_mem[chosen];
      cnt_hit <= cnt_vld[chosen];
    end
  end

  rvaa_wmul #(
    .AW(MAG_W),
    .BW(MAG_W)
  ) u_sq (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .a    (d_mag),
    .b    (d_mag),
    .done (sq_done),
    .p    (sq_p)
  );

  rvaa_wmul #(
    .AW(DSQ_W),
    .BW(NRM_W)
  ) u_lhs (
    .clk  (clk),
    .rst  (rst),
    .start(cmp_start),
    .a    (sq_p),
    .b    (bn),
    .done (lhs_done),
    .p    (lhs_p)
  );

  rvaa_wmul #(
    .AW(DSQ_W),
    .BW(NRM_W)
  ) u_rhs (
    .clk  (clk),
    .rst  (rst),
    .start(cmp_start),
    .a    (bd2),
    .b    (cn),
    .done (rhs_done),
    .p    (rhs_p)
  );

endmodule
